[hw/rtl/gripper_motion_settle_monitor_top_macros.svh]
// Assertion macros for the gripper motion settle monitor.
// Included by the top level; needs no other file.
`ifndef GRIPPER_MOTION_SETTLE_MONITOR_TOP_MACROS_SVH
`define GRIPPER_MOTION_SETTLE_MONITOR_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GMSM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gmsm: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define GMSM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gmsm: next-cycle check failed");

`endif

[hw/rtl/gmsm_pkg.sv]
// Shared types, codes and helpers of the gripper motion settle monitor.
// No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps

package gmsm_pkg;

   localparam int unsigned SampleWidth = 16;
   localparam int unsigned MarginWidth = 15;
   localparam int unsigned TickWidth   = 16;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDatWidth = 16;

   typedef logic [CsrIdxWidth-1:0]        csr_index_type;
   typedef logic [CsrDatWidth-1:0]        csr_data_type;
   typedef logic signed [SampleWidth-1:0] sample_type;
   typedef logic [MarginWidth-1:0]        margin_type;
   typedef logic [TickWidth-1:0]          tick_type;
   typedef logic [SampleWidth:0]          diff_type;

   // Register indexes of the configuration port.
   localparam csr_index_type CSR_FORCE_LIMIT   = 3'd0;
   localparam csr_index_type CSR_MOVE_MARGIN   = 3'd1;
   localparam csr_index_type CSR_SETTLE_MARGIN = 3'd2;
   localparam csr_index_type CSR_SETTLE_TICKS  = 3'd3;
   localparam csr_index_type CSR_TIMEOUT_TICKS = 3'd4;

   // Register reset values (Q5.10 for the margins, ticks for the counts).
   localparam margin_type RST_FORCE_LIMIT   = 15'd3174;
   localparam margin_type RST_MOVE_MARGIN   = 15'd102;
   localparam margin_type RST_SETTLE_MARGIN = 15'd51;
   localparam tick_type   RST_SETTLE_TICKS  = 16'd20;
   localparam tick_type   RST_TIMEOUT_TICKS = 16'd500;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_OPEN  = 2'd1;
   localparam logic [1:0] OP_CLOSE = 2'd2;

   typedef enum logic [1:0] {
      STATUS_IDLE    = 2'd0,
      STATUS_BUSY    = 2'd1,
      STATUS_OK      = 2'd2,
      STATUS_TIMEOUT = 2'd3
   } status_type;

   // Magnitude of a - b; the 17-bit difference always fits its own magnitude.
   function automatic diff_type abs_diff(input sample_type a, input sample_type b);
      logic signed [SampleWidth:0] d;
      d = {a[SampleWidth-1], a} - {b[SampleWidth-1], b};
      return d[SampleWidth] ? diff_type'(-d) : diff_type'(d);
   endfunction

endpackage

[hw/rtl/gmsm_ifs.sv]
// Handshake interfaces for the request and response channels.
// Depends on gmsm_pkg for the sample and status types.
`timescale 1ns / 1ps

interface gmsm_req_if;
   import gmsm_pkg::*;

   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic       sample_valid;
   sample_type sample_position;
   sample_type sample_force;

   modport source (output valid, opcode, sample_valid, sample_position, sample_force,
                   input ready);
   modport sink (input valid, opcode, sample_valid, sample_position, sample_force,
                 output ready);
endinterface

interface gmsm_rsp_if;
   import gmsm_pkg::*;

   logic       valid;
   logic       ready;
   logic       drive_level;
   status_type status;
   logic       motion_started;

   modport source (output valid, drive_level, status, motion_started, input ready);
   modport sink (input valid, drive_level, status, motion_started, output ready);
endinterface

[hw/rtl/gripper_motion_settle_monitor_top.sv]
// Gripper motion settle monitor: one response word per request word.
// The response is registered and is valid in the cycle after the request is accepted.
// Throughput: 1 word per cycle; the single output register is the only stage
// and the request side stalls only while a response waits to be taken.
// Reset (synchronous, active high) clears the monitor flags, counters and response valid
// and loads the configuration registers with their default values.
`timescale 1ns / 1ps
`include "gripper_motion_settle_monitor_top_macros.svh"

module gripper_motion_settle_monitor_top (
   input  logic                   clock,
   input  logic                   reset,
   gmsm_req_if.sink               req_if,
   gmsm_rsp_if.source             rsp_if,
   input  logic                   csr_wr_en,
   input  gmsm_pkg::csr_index_type csr_index,
   input  gmsm_pkg::csr_data_type  csr_wdata
);
   import gmsm_pkg::*;

   // Configuration registers.
   margin_type force_limit_ff, move_margin_ff, settle_margin_ff;
   tick_type   settle_ticks_ff, timeout_ticks_ff;

   // Monitor state.
   logic       drive_ff, drive_in;
   logic       active_ff, active_in;
   logic       have_sample_ff, have_sample_in;
   logic       have_start_ff, have_start_in;
   logic       started_ff, started_in;
   sample_type latest_pos_ff, latest_pos_in;
   sample_type latest_force_ff, latest_force_in;
   sample_type start_pos_ff, start_pos_in;
   sample_type settle_ref_ff, settle_ref_in;
   tick_type   elapsed_ff, elapsed_in;
   tick_type   stable_ff, stable_in;

   // Response register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_drive_ff;
   status_type rsp_status_ff, status_in;
   logic       rsp_started_ff;

   logic       req_fire;
   logic       is_cmd;
   logic       fresh;
   logic       force_hit;
   logic       settle_moved;
   tick_type   stable_base;
   sample_type cur_pos, cur_force, start_sel, ref_sel;
   diff_type   move_diff, settle_diff;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;
   assign is_cmd       = req_if.opcode inside {OP_OPEN, OP_CLOSE};

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.drive_level    = rsp_drive_ff;
   assign rsp_if.status         = rsp_status_ff;
   assign rsp_if.motion_started = rsp_started_ff;

   // Sample seen by this tick, and the references it is checked against.
   assign cur_pos   = req_if.sample_valid ? req_if.sample_position : latest_pos_ff;
   assign cur_force = req_if.sample_valid ? req_if.sample_force : latest_force_ff;
   assign fresh     = !have_start_ff;
   assign start_sel = fresh ? cur_pos : start_pos_ff;
   assign ref_sel   = fresh ? cur_pos : settle_ref_ff;
   assign move_diff   = abs_diff(cur_pos, start_sel);
   assign settle_diff = abs_diff(cur_pos, ref_sel);
   assign force_hit   = $signed({cur_force[SampleWidth-1], cur_force})
                        > $signed({2'b00, force_limit_ff});
   assign settle_moved = settle_diff > {2'b00, settle_margin_ff};
   assign stable_base  = fresh ? '0 : stable_ff;

   always_comb begin
      drive_in        = drive_ff;
      active_in       = active_ff;
      have_sample_in  = have_sample_ff;
      have_start_in   = have_start_ff;
      started_in      = started_ff;
      latest_pos_in   = latest_pos_ff;
      latest_force_in = latest_force_ff;
      start_pos_in    = start_pos_ff;
      settle_ref_in   = settle_ref_ff;
      elapsed_in      = elapsed_ff;
      stable_in       = stable_ff;
      status_in       = STATUS_IDLE;
      if (is_cmd) begin
         drive_in       = (req_if.opcode == OP_CLOSE);
         active_in      = 1'b1;
         have_sample_in = 1'b0;
         have_start_in  = 1'b0;
         started_in     = 1'b0;
         elapsed_in     = '0;
         stable_in      = '0;
         status_in      = STATUS_BUSY;
      end else begin
         latest_pos_in   = cur_pos;
         latest_force_in = cur_force;
         have_sample_in  = have_sample_ff || req_if.sample_valid;
         if (active_ff) begin
            if (elapsed_ff >= timeout_ticks_ff) begin
               active_in = 1'b0;
               status_in = STATUS_TIMEOUT;
            end else begin
               elapsed_in = elapsed_ff + tick_type'(1);
               status_in  = STATUS_BUSY;
               if (have_sample_in) begin
                  have_start_in = 1'b1;
                  start_pos_in  = start_sel;
                  started_in    = started_ff || force_hit
                                  || (move_diff > {2'b00, move_margin_ff});
                  if (settle_moved) begin
                     settle_ref_in = cur_pos;
                     stable_in     = '0;
                  end else begin
                     settle_ref_in = ref_sel;
                     if (!fresh && stable_ff != '1) begin
                        stable_in = stable_ff + tick_type'(1);
                     end else begin
                        stable_in = stable_base;
                     end
                  end
                  if (started_in && stable_in > settle_ticks_ff) begin
                     active_in = 1'b0;
                     status_in = STATUS_OK;
                  end
               end
            end
         end
      end
   end

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         force_limit_ff   <= RST_FORCE_LIMIT;
         move_margin_ff   <= RST_MOVE_MARGIN;
         settle_margin_ff <= RST_SETTLE_MARGIN;
         settle_ticks_ff  <= RST_SETTLE_TICKS;
         timeout_ticks_ff <= RST_TIMEOUT_TICKS;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FORCE_LIMIT:   force_limit_ff   <= csr_wdata[MarginWidth-1:0];
            CSR_MOVE_MARGIN:   move_margin_ff   <= csr_wdata[MarginWidth-1:0];
            CSR_SETTLE_MARGIN: settle_margin_ff <= csr_wdata[MarginWidth-1:0];
            CSR_SETTLE_TICKS:  settle_ticks_ff  <= csr_wdata[TickWidth-1:0];
            CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wdata[TickWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff       <= 1'b0;
         active_ff      <= 1'b0;
         have_sample_ff <= 1'b0;
         have_start_ff  <= 1'b0;
         started_ff     <= 1'b0;
         elapsed_ff     <= '0;
         stable_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            drive_ff       <= drive_in;
            active_ff      <= active_in;
            have_sample_ff <= have_sample_in;
            have_start_ff  <= have_start_in;
            started_ff     <= started_in;
            elapsed_ff     <= elapsed_in;
            stable_ff      <= stable_in;
         end
      end
   end

   // Sample and reference registers are only read once their flags are set.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         latest_pos_ff   <= latest_pos_in;
         latest_force_ff <= latest_force_in;
         start_pos_ff    <= start_pos_in;
         settle_ref_ff   <= settle_ref_in;
         rsp_drive_ff    <= drive_in;
         rsp_status_ff   <= status_in;
         rsp_started_ff  <= started_in;
      end
   end

   `GMSM_ASSERT_NEXT(a_cmd_reports_busy, clock, reset, req_fire && is_cmd,
      rsp_if.valid && rsp_if.status == STATUS_BUSY && !rsp_if.motion_started && active_ff)
   `GMSM_ASSERT_NEXT(a_idle_tick_reports_idle, clock, reset, req_fire && !is_cmd && !active_ff,
      rsp_if.valid && rsp_if.status == STATUS_IDLE && !active_ff)
   `GMSM_ASSERT_IMPLY(a_outcome_disarms, clock, reset,
      rsp_valid_ff && (rsp_status_ff == STATUS_OK || rsp_status_ff == STATUS_TIMEOUT),
      !active_ff)

endmodule
